/* hdl/crlc_pkg.sv */
package crlc_pkg;

  localparam logic [7:0] OP_CALL        = 8'd208;
  localparam logic [7:0] OP_CALL_ACK    = 8'd209;
  localparam logic [7:0] OP_POLL        = 8'd212;
  localparam logic [7:0] OP_POLL_ACK    = 8'd213;
  localparam logic [7:0] GOOD_LENGTH    = 8'd3;

  localparam logic [7:0]  OWN_ADDRESS_RST   = 8'd4;
  localparam logic [31:0] START_FREQ_RST    = 32'd434000000;
  localparam logic [15:0] PING_TIMEOUT_RST  = 16'd5000;
  localparam logic [15:0] CUTOFF_RST        = 16'd2000;
  localparam logic [7:0]  LED_BRIGHT_RST    = 8'd35;
  localparam logic [7:0]  BUZZER_VOLUME_RST = 8'd255;

  localparam int FREQ_ERR_W = 21;

  typedef enum logic [2:0] {
    REG_OWN_ADDRESS   = 3'd0,
    REG_START_FREQ    = 3'd1,
    REG_PING_TIMEOUT  = 3'd2,
    REG_CUTOFF        = 3'd3,
    REG_LED_BRIGHT    = 3'd4,
    REG_BUZZER_VOLUME = 3'd5
  } cfg_reg_t;

  typedef enum logic [1:0] {
    BLINK_NONE    = 2'd0,
    BLINK_PING    = 2'd1,
    BLINK_TIMEOUT = 2'd2
  } blink_t;

endpackage

/* hdl/call_receiver_link_controller_top.sv */
// Receiver-side controller of a paging link. Each transfer on the input channel is
// either a one-millisecond tick (kind 0) or a received packet (kind 1), and yields
// exactly one result transfer carrying the reply to send, if any, together with the
// present LED, buzzer, status LED and blink levels and the corrected tuned frequency.
// An item passes through an input register and the update logic into the result
// register, which presents the result; the block takes one item per cycle, and it
// stalls only when the result register is full and not being taken. Registers are
// written through the configuration channel (index 0 own address, 1 start
// frequency, 2 ping timeout, 3 cutoff, 4 LED brightness, 5 buzzer volume; higher
// indexes are ignored), which is always ready and should be used only while no item
// is in flight. Writing the start frequency also loads it at once as the tuned
// frequency that later results carry and correct.
module call_receiver_link_controller_top
  import crlc_pkg::*;
#(
  parameter int COUNTER_BITS = 17
) (
  input  logic                         clk,
  input  logic                         rst,

  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [2:0]                   cfg_index,
  input  logic [31:0]                  cfg_data,

  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         kind,
  input  logic [7:0]                   packet_length,
  input  logic [7:0]                   dest_address,
  input  logic [7:0]                   command,
  input  logic [7:0]                   payload,
  input  logic signed [FREQ_ERR_W-1:0] frequency_error,

  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         reply_valid,
  output logic [7:0]                   reply_address,
  output logic [7:0]                   reply_command,
  output logic                         reply_data,
  output logic [7:0]                   led_level,
  output logic [7:0]                   buzzer_level,
  output logic                         status_led,
  output logic [1:0]                   blink_request,
  output logic [31:0]                  tuned_frequency,
  output logic                         packet_accepted
);

  localparam int CMP_W = (COUNTER_BITS > 16) ? COUNTER_BITS : 16;
  localparam logic [COUNTER_BITS-1:0] COUNT_MAX = {COUNTER_BITS{1'b1}};

  logic [7:0]  own_address;
  logic [31:0] start_frequency;
  logic [15:0] ping_timeout_ticks;
  logic [15:0] cutoff_ticks;
  logic [7:0]  led_brightness;
  logic [7:0]  buzzer_volume;

  logic                         s1_valid;
  logic                         s1_kind;
  logic [7:0]                   s1_length;
  logic [7:0]                   s1_address;
  logic [7:0]                   s1_command;
  logic [7:0]                   s1_payload;
  logic signed [FREQ_ERR_W-1:0] s1_freq_err;

  logic                    signal_on;
  logic [COUNTER_BITS-1:0] ping_elapsed;
  logic [COUNTER_BITS-1:0] cutoff_elapsed;
  logic [31:0]             frequency_now;
  logic [7:0]              led_now;
  logic [7:0]              buzzer_now;
  logic                    status_now;

  logic                    signal_on_next;
  logic [COUNTER_BITS-1:0] ping_elapsed_next;
  logic [COUNTER_BITS-1:0] cutoff_elapsed_next;
  logic [31:0]             frequency_now_next;
  logic [7:0]              led_now_next;
  logic [7:0]              buzzer_now_next;
  logic                    status_now_next;
  logic                    reply_valid_next;
  logic [7:0]              reply_address_next;
  logic [7:0]              reply_command_next;
  logic                    reply_data_next;
  blink_t                  blink_next;
  logic                    accepted_next;

  logic s2_adv;
  logic s1_adv;

  assign cfg_ready = 1'b1;
  assign s2_adv    = s1_valid && (!out_valid || out_ready);
  assign in_ready  = !s1_valid || s2_adv;
  assign s1_adv    = in_valid && in_ready;

  always_comb begin
    logic                    is_match;
    logic                    err_neg;
    logic [FREQ_ERR_W-1:0]   err_mag;
    logic [FREQ_ERR_W-2:0]   err_half;
    logic [COUNTER_BITS-1:0] ping_inc;
    logic [COUNTER_BITS-1:0] cutoff_inc;
    logic                    call_on;

    signal_on_next      = signal_on;
    ping_elapsed_next   = ping_elapsed;
    cutoff_elapsed_next = cutoff_elapsed;
    frequency_now_next  = frequency_now;
    led_now_next        = led_now;
    buzzer_now_next     = buzzer_now;
    status_now_next     = status_now;
    reply_valid_next    = 1'b0;
    reply_address_next  = 8'd0;
    reply_command_next  = 8'd0;
    reply_data_next     = 1'b0;
    blink_next          = BLINK_NONE;
    accepted_next       = 1'b0;

    is_match = (s1_length == GOOD_LENGTH) && (s1_address == own_address);
    err_neg  = s1_freq_err[FREQ_ERR_W-1];
    err_mag  = err_neg ? (~s1_freq_err + 1'b1) : s1_freq_err;
    err_half = err_mag[FREQ_ERR_W-1:1];
    call_on  = (s1_payload != 8'd0);
    ping_inc   = (ping_elapsed == COUNT_MAX) ? COUNT_MAX : ping_elapsed + 1'b1;
    cutoff_inc = (cutoff_elapsed == COUNT_MAX) ? COUNT_MAX : cutoff_elapsed + 1'b1;

    if (s1_kind) begin
      if (is_match) begin
        accepted_next = 1'b1;
        if (err_neg) begin
          frequency_now_next = frequency_now + {{(32-FREQ_ERR_W+1){1'b0}}, err_half};
        end else begin
          frequency_now_next = frequency_now - {{(32-FREQ_ERR_W+1){1'b0}}, err_half};
        end
        if (s1_command == OP_CALL || s1_command == OP_POLL) begin
          signal_on_next      = call_on;
          led_now_next        = call_on ? led_brightness : 8'd0;
          buzzer_now_next     = call_on ? buzzer_volume : 8'd0;
          status_now_next     = call_on;
          cutoff_elapsed_next = '0;
        end
        if (s1_command == OP_CALL && call_on) begin
          reply_valid_next   = 1'b1;
          reply_address_next = s1_address;
          reply_command_next = OP_CALL_ACK;
          reply_data_next    = 1'b1;
        end
        if (s1_command == OP_POLL) begin
          status_now_next    = 1'b0;
          blink_next         = BLINK_PING;
          reply_valid_next   = 1'b1;
          reply_address_next = s1_address;
          reply_command_next = OP_POLL_ACK;
          reply_data_next    = call_on;
        end
        if (reply_valid_next) begin
          ping_elapsed_next = '0;
        end
      end
    end else begin
      ping_elapsed_next   = ping_inc;
      cutoff_elapsed_next = cutoff_inc;
      if (CMP_W'(ping_inc) > CMP_W'(ping_timeout_ticks)) begin
        signal_on_next    = 1'b0;
        ping_elapsed_next = '0;
        status_now_next   = 1'b0;
        blink_next        = BLINK_TIMEOUT;
      end
      if (CMP_W'(cutoff_inc) > CMP_W'(cutoff_ticks)) begin
        signal_on_next  = 1'b0;
        led_now_next    = 8'd0;
        buzzer_now_next = 8'd0;
        status_now_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      own_address        <= OWN_ADDRESS_RST;
      start_frequency    <= START_FREQ_RST;
      ping_timeout_ticks <= PING_TIMEOUT_RST;
      cutoff_ticks       <= CUTOFF_RST;
      led_brightness     <= LED_BRIGHT_RST;
      buzzer_volume      <= BUZZER_VOLUME_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_OWN_ADDRESS:   own_address        <= cfg_data[7:0];
        REG_START_FREQ:    start_frequency    <= cfg_data;
        REG_PING_TIMEOUT:  ping_timeout_ticks <= cfg_data[15:0];
        REG_CUTOFF:        cutoff_ticks       <= cfg_data[15:0];
        REG_LED_BRIGHT:    led_brightness     <= cfg_data[7:0];
        REG_BUZZER_VOLUME: buzzer_volume      <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s1_kind     <= kind;
      s1_length   <= packet_length;
      s1_address  <= dest_address;
      s1_command  <= command;
      s1_payload  <= payload;
      s1_freq_err <= frequency_error;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      signal_on      <= 1'b0;
      ping_elapsed   <= '0;
      cutoff_elapsed <= '0;
      frequency_now  <= START_FREQ_RST;
      led_now        <= 8'd0;
      buzzer_now     <= 8'd0;
      status_now     <= 1'b0;
    end else if (cfg_valid && cfg_index == REG_START_FREQ) begin
      frequency_now <= cfg_data;
    end else if (s2_adv) begin
      signal_on      <= signal_on_next;
      ping_elapsed   <= ping_elapsed_next;
      cutoff_elapsed <= cutoff_elapsed_next;
      frequency_now  <= frequency_now_next;
      led_now        <= led_now_next;
      buzzer_now     <= buzzer_now_next;
      status_now     <= status_now_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s2_adv) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_adv) begin
      reply_valid     <= reply_valid_next;
      reply_address   <= reply_address_next;
      reply_command   <= reply_command_next;
      reply_data      <= reply_data_next;
      led_level       <= led_now_next;
      buzzer_level    <= buzzer_now_next;
      status_led      <= status_now_next;
      blink_request   <= blink_next;
      tuned_frequency <= frequency_now_next;
      packet_accepted <= accepted_next;
    end
  end

  a_reply_needs_accept: assert property (@(posedge clk) disable iff (rst)
    out_valid && reply_valid |-> packet_accepted)
    else $error("reply without an accepted packet");

  a_reply_clears_ping: assert property (@(posedge clk) disable iff (rst)
    s2_adv && reply_valid_next |=> ping_elapsed == '0)
    else $error("ping timer not restarted by reply");

  a_stalled_item_held: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s2_adv |=> s1_valid && $stable(s1_command) && $stable(s1_kind))
    else $error("stalled item lost");

  a_reset_frequency: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> frequency_now == start_frequency)
    else $error("tuned frequency not loaded at reset");

  a_timeout_blink_clears: assert property (@(posedge clk) disable iff (rst)
    s2_adv && blink_next == BLINK_TIMEOUT |=> !signal_on && ping_elapsed == '0)
    else $error("ping timeout left link state set");

endmodule

/* tb/tb.sv */
module tb
  import crlc_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CNT_BITS = 17;
  localparam logic [CNT_BITS-1:0] CNT_MAX = '1;
  localparam int QUIET_LIMIT = 400;
  localparam logic [2:0] REG_SPARE_LO = 3'd6;
  localparam logic [2:0] REG_SPARE_HI = 3'd7;

  typedef struct packed {
    logic                         kind;
    logic [7:0]                   len;
    logic [7:0]                   addr;
    logic [7:0]                   cmd;
    logic [7:0]                   pay;
    logic signed [FREQ_ERR_W-1:0] ferr;
  } link_item_t;

  typedef struct packed {
    logic        rv;
    logic [7:0]  raddr;
    logic [7:0]  rcmd;
    logic        rdata;
    logic [7:0]  led;
    logic [7:0]  buzz;
    logic        status;
    blink_t      blink;
    logic [31:0] freq;
    logic        acc;
  } link_result_t;

  typedef struct packed {
    link_item_t   it;
    logic         fixed;
    link_result_t res;
  } call_row_t;

  localparam link_result_t HELD_ON = '{1'b0, 8'd0, 8'd0, 1'b0, LED_BRIGHT_RST,
                                       BUZZER_VOLUME_RST, 1'b1, BLINK_NONE,
                                       START_FREQ_RST, 1'b0};

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  logic                         in_valid = 1'b0;
  logic                         in_ready;
  logic                         kind = 1'b0;
  logic [7:0]                   packet_length = '0;
  logic [7:0]                   dest_address = '0;
  logic [7:0]                   command = '0;
  logic [7:0]                   payload = '0;
  logic signed [FREQ_ERR_W-1:0] frequency_error = '0;

  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        reply_valid;
  logic [7:0]  reply_address;
  logic [7:0]  reply_command;
  logic        reply_data;
  logic [7:0]  led_level;
  logic [7:0]  buzzer_level;
  logic        status_led;
  logic [1:0]  blink_request;
  logic [31:0] tuned_frequency;
  logic        packet_accepted;

  call_receiver_link_controller_top #(.COUNTER_BITS(CNT_BITS)) uut (.*);

  always #6 clk = ~clk;

  logic [7:0]          cfg_own = OWN_ADDRESS_RST;
  logic [15:0]         cfg_ping = PING_TIMEOUT_RST;
  logic [15:0]         cfg_cut = CUTOFF_RST;
  logic [7:0]          cfg_led = LED_BRIGHT_RST;
  logic [7:0]          cfg_buzz = BUZZER_VOLUME_RST;
  logic                sig_on = 1'b0;
  logic [CNT_BITS-1:0] ping_cnt = '0;
  logic [CNT_BITS-1:0] cut_cnt = '0;
  logic [31:0]         freq_now = START_FREQ_RST;
  logic [7:0]          led_now = '0;
  logic [7:0]          buzz_now = '0;
  logic                status_now = 1'b0;

  link_result_t pending_results[$];
  int           n_bad = 0;
  int           quiet_cycles = 0;
  bit           steady = 1'b0;
  call_row_t    call_script [18];

  function automatic link_result_t advance_link(link_item_t it);
    link_result_t r;
    logic signed [FREQ_ERR_W-1:0] half;
    r = '0;
    r.blink = BLINK_NONE;
    if (it.kind) begin
      if (it.len == GOOD_LENGTH && it.addr == cfg_own) begin
        r.acc = 1'b1;
        half = $signed(it.ferr) / 21'sd2;
        freq_now = freq_now - {{(32-FREQ_ERR_W){half[FREQ_ERR_W-1]}}, half};
        if (it.cmd == OP_CALL || it.cmd == OP_POLL) begin
          sig_on = (it.pay != 8'd0);
          led_now = sig_on ? cfg_led : 8'd0;
          buzz_now = sig_on ? cfg_buzz : 8'd0;
          status_now = sig_on;
          cut_cnt = '0;
          if (it.cmd == OP_POLL) begin
            status_now = 1'b0;
            r.blink = BLINK_PING;
            r.rv = 1'b1;
            r.raddr = it.addr;
            r.rcmd = OP_POLL_ACK;
            r.rdata = sig_on;
          end else if (sig_on) begin
            r.rv = 1'b1;
            r.raddr = it.addr;
            r.rcmd = OP_CALL_ACK;
            r.rdata = 1'b1;
          end
          if (r.rv) ping_cnt = '0;
        end
      end
    end else begin
      ping_cnt = (ping_cnt == CNT_MAX) ? CNT_MAX : ping_cnt + 1'b1;
      cut_cnt = (cut_cnt == CNT_MAX) ? CNT_MAX : cut_cnt + 1'b1;
      if (ping_cnt > cfg_ping) begin
        sig_on = 1'b0;
        ping_cnt = '0;
        status_now = 1'b0;
        r.blink = BLINK_TIMEOUT;
      end
      if (cut_cnt > cfg_cut) begin
        sig_on = 1'b0;
        led_now = '0;
        buzz_now = '0;
        status_now = 1'b0;
      end
    end
    r.led = led_now;
    r.buzz = buzz_now;
    r.status = status_now;
    r.freq = freq_now;
    return r;
  endfunction

  function automatic int draw_wait();
    return steady ? 0 : int'($urandom_range(0, 8));
  endfunction

  function automatic link_item_t make_item(int tick_pct);
    link_item_t it;
    int pick;
    it.kind = ($urandom_range(0, 99) >= tick_pct);
    it.len = 8'($urandom);
    it.addr = 8'($urandom);
    it.cmd = 8'($urandom);
    it.pay = ($urandom_range(0, 2) == 0) ? 8'd0 : 8'($urandom);
    it.ferr = FREQ_ERR_W'($urandom);
    pick = $urandom_range(0, 9);
    if (it.kind && $urandom_range(0, 3) != 0) begin
      it.len = GOOD_LENGTH;
      it.addr = cfg_own;
      if (pick < 4) it.cmd = OP_CALL;
      else if (pick < 8) it.cmd = OP_POLL;
    end else if (it.kind) begin
      if (pick < 3) it.len = GOOD_LENGTH;
      if (pick > 6) it.addr = cfg_own;
    end
    return it;
  endfunction

  task automatic send_item(input link_item_t it, input logic fixed = 1'b0,
                           input link_result_t fixed_res = '0);
    int gap;
    link_result_t predicted;
    gap = draw_wait();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    kind <= it.kind;
    packet_length <= it.len;
    dest_address <= it.addr;
    command <= it.cmd;
    payload <= it.pay;
    frequency_error <= it.ferr;
    do @(posedge clk); while (!in_ready);
    predicted = advance_link(it);
    pending_results.push_back(fixed ? fixed_res : predicted);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_OWN_ADDRESS:   cfg_own = val[7:0];
      REG_START_FREQ:    freq_now = val;
      REG_PING_TIMEOUT:  cfg_ping = val[15:0];
      REG_CUTOFF:        cfg_cut = val[15:0];
      REG_LED_BRIGHT:    cfg_led = val[7:0];
      REG_BUZZER_VOLUME: cfg_buzz = val[7:0];
      default: ;
    endcase
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic run_calls(input int n, input int tick_pct);
    for (int i = 0; i < n; i++) begin
      if (i % 50 == 0) steady = ($urandom_range(0, 3) == 0);
      send_item(make_item(tick_pct));
    end
  endtask

  task automatic load_random_setup();
    write_reg(REG_OWN_ADDRESS, $urandom_range(0, 255));
    write_reg(REG_START_FREQ, $urandom);
    write_reg(REG_PING_TIMEOUT, $urandom_range(1, 60));
    write_reg(REG_CUTOFF, $urandom_range(1, 60));
    write_reg(REG_LED_BRIGHT, $urandom_range(0, 255));
    write_reg(REG_BUZZER_VOLUME, $urandom_range(0, 255));
  endtask

  initial begin
    call_script = '{
      '{'{1'b0, 8'd0, 8'd0, 8'd0, 8'd0, 21'sd0}, 1'b1,
        '{1'b0, 8'd0, 8'd0, 1'b0, 8'd0, 8'd0, 1'b0, BLINK_NONE, START_FREQ_RST, 1'b0}},
      '{'{1'b1, GOOD_LENGTH, OWN_ADDRESS_RST, OP_CALL, 8'd1, 21'sd0}, 1'b1,
        '{1'b1, OWN_ADDRESS_RST, OP_CALL_ACK, 1'b1, LED_BRIGHT_RST,
          BUZZER_VOLUME_RST, 1'b1, BLINK_NONE, START_FREQ_RST, 1'b1}},
      '{'{1'b1, 8'd2, OWN_ADDRESS_RST, OP_CALL, 8'd0, 21'sd1000}, 1'b1, HELD_ON},
      '{'{1'b1, 8'd4, OWN_ADDRESS_RST, OP_POLL, 8'd1, 21'sd0}, 1'b1, HELD_ON},
      '{'{1'b1, GOOD_LENGTH, 8'd5, OP_CALL, 8'd0, 21'sd0}, 1'b1, HELD_ON},
      '{'{1'b1, 8'd255, 8'd255, 8'd255, 8'd255, 21'sd1048575}, 1'b1, HELD_ON},
      '{'{1'b1, 8'd0, 8'd0, 8'd0, 8'd0, -21'sd1048576}, 1'b1, HELD_ON},
      '{'{1'b1, GOOD_LENGTH, OWN_ADDRESS_RST, 8'd0, 8'd0, 21'sd1048575}, 1'b1,
        '{1'b0, 8'd0, 8'd0, 1'b0, LED_BRIGHT_RST, BUZZER_VOLUME_RST, 1'b1,
          BLINK_NONE, START_FREQ_RST - 32'd524287, 1'b1}},
      '{'{1'b1, GOOD_LENGTH, OWN_ADDRESS_RST, 8'd255, 8'd255, -21'sd1048576}, 1'b0, '0},
      '{'{1'b1, GOOD_LENGTH, OWN_ADDRESS_RST, OP_CALL_ACK, 8'd1, -21'sd1}, 1'b0, '0},
      '{'{1'b1, GOOD_LENGTH, OWN_ADDRESS_RST, OP_POLL_ACK, 8'd0, 21'sd1}, 1'b0, '0},
      '{'{1'b1, GOOD_LENGTH, OWN_ADDRESS_RST, OP_POLL, 8'd0, -21'sd3}, 1'b0, '0},
      '{'{1'b1, GOOD_LENGTH, OWN_ADDRESS_RST, OP_POLL, 8'd255, 21'sd2}, 1'b0, '0},
      '{'{1'b1, GOOD_LENGTH, OWN_ADDRESS_RST, OP_CALL, 8'd0, 21'sd0}, 1'b0, '0},
      '{'{1'b1, GOOD_LENGTH, OWN_ADDRESS_RST, OP_CALL, 8'd128, 21'sd12345}, 1'b0, '0},
      '{'{1'b0, 8'd170, 8'd85, 8'd170, 8'd85, 21'sh0AAAAA}, 1'b0, '0},
      '{'{1'b1, GOOD_LENGTH, OWN_ADDRESS_RST, OP_POLL, 8'd170, 21'sh0AAAAA}, 1'b0, '0},
      '{'{1'b1, GOOD_LENGTH, OWN_ADDRESS_RST, OP_CALL, 8'd85, 21'sh155555}, 1'b0, '0}
    };

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (call_script[i]) send_item(call_script[i].it, call_script[i].fixed,
                                       call_script[i].res);
    settle();

    write_reg(REG_OWN_ADDRESS, 32'd0);
    write_reg(REG_START_FREQ, 32'd0);
    write_reg(REG_PING_TIMEOUT, 32'd1);
    write_reg(REG_CUTOFF, 32'd1);
    write_reg(REG_LED_BRIGHT, 32'd0);
    write_reg(REG_BUZZER_VOLUME, 32'd0);
    write_reg(REG_SPARE_LO, 32'hFFFF_FFFF);
    write_reg(REG_SPARE_HI, 32'hFFFF_FFFF);
    run_calls(300, 50);
    settle();

    write_reg(REG_OWN_ADDRESS, 32'd255);
    write_reg(REG_START_FREQ, 32'hFFFF_FFFF);
    write_reg(REG_PING_TIMEOUT, 32'd2);
    write_reg(REG_CUTOFF, 32'd3);
    write_reg(REG_LED_BRIGHT, 32'd255);
    write_reg(REG_BUZZER_VOLUME, 32'd1);
    run_calls(300, 40);
    settle();

    write_reg(REG_PING_TIMEOUT, 32'd65535);
    write_reg(REG_CUTOFF, 32'd65535);
    write_reg(REG_BUZZER_VOLUME, 32'd255);
    steady = 1'b1;
    send_item('{1'b1, GOOD_LENGTH, cfg_own, OP_CALL, 8'd1, 21'sd0});
    repeat (40) send_item('0);
    settle();

    repeat (3) begin
      load_random_setup();
      run_calls(300, $urandom_range(20, 80));
      settle();
    end

    if (n_bad == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

  initial begin
    int stall;
    link_result_t seen;
    link_result_t want;
    while (rst) @(posedge clk);
    forever begin
      stall = draw_wait();
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      seen = '{reply_valid, reply_address, reply_command, reply_data, led_level,
               buzzer_level, status_led, blink_t'(blink_request), tuned_frequency,
               packet_accepted};
      if (pending_results.size() == 0) begin
        if (n_bad < 10) $display("unexpected result transfer at %0t", $realtime);
        n_bad++;
      end else begin
        want = pending_results.pop_front();
        if (seen !== want) begin
          if (n_bad < 10) begin
            $display("mismatch at %0t", $realtime);
            $display("  exp rv=%0d ad=%0d cmd=%0d d=%0d led=%0d bz=%0d st=%0d bl=%0d f=%0d a=%0d",
                     want.rv, want.raddr, want.rcmd, want.rdata, want.led, want.buzz,
                     want.status, want.blink, want.freq, want.acc);
            $display("  got rv=%0d ad=%0d cmd=%0d d=%0d led=%0d bz=%0d st=%0d bl=%0d f=%0d a=%0d",
                     seen.rv, seen.raddr, seen.rcmd, seen.rdata, seen.led, seen.buzz,
                     seen.status, seen.blink, seen.freq, seen.acc);
          end
          n_bad++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
